### rtl/assert_macros.svh
// assertion macros used by the top-level rtl file
// no dependencies; define NO_ASSERTIONS to compile them away
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// clocked check, disabled while reset is low
`define ASSERT_CLK_RST(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// clocked check that also holds during reset
`define ASSERT_CLK(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define ASSERT_CLK_RST(lbl, clk, rst_n, prop, msg)
`define ASSERT_CLK(lbl, clk, prop, msg)
`endif
`endif

### rtl/kbd_pkg.sv
// shared types, codes and the character rom for the scan code decoder
// no dependencies
package kbd_pkg;

  // scan code values
  localparam logic [7:0] PREFIX_BYTE  = 8'hE0;
  localparam logic [6:0] KEY_CTRL     = 7'h1D;
  localparam logic [6:0] KEY_SHIFT_L  = 7'h2A;
  localparam logic [6:0] KEY_SHIFT_R  = 7'h36;
  localparam logic [6:0] KEY_ALT      = 7'h38;
  localparam logic [6:0] KEY_CAPS     = 7'h3A;
  localparam logic [7:0] ROM_LIMIT    = 8'h3B;
  localparam logic [7:0] DIGIT_LIMIT  = 8'h0E;
  localparam logic [7:0] KEY_BACKTICK = 8'h29;

  localparam int ROM_DEPTH   = 59;
  localparam int ROM_AW      = $clog2(ROM_DEPTH);
  localparam int STATE_DEPTH = 1;

  // decoder state held in the state memory
  typedef struct packed {
    logic extend;
    logic ctrl;
    logic shift;
    logic alt;
    logic caps;
  } kbd_state_t;

  localparam int STATE_W = $bits(kbd_state_t);

  // one decoded item
  typedef struct packed {
    logic       emit;
    logic [6:0] ascii_char;
    logic       ctrl_held;
    logic       alt_held;
  } kbd_result_t;

  // unshifted column
  localparam logic [6:0] ROM_LO [0:ROM_DEPTH-1] = '{
    7'h00, 7'h1B, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38,
    7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09, 7'h71, 7'h77, 7'h65, 7'h72,
    7'h74, 7'h79, 7'h75, 7'h69, 7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0D, 7'h00,
    7'h61, 7'h73, 7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
    7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76, 7'h62, 7'h6E,
    7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A, 7'h00, 7'h20, 7'h00
  };

  // shifted column
  localparam logic [6:0] ROM_HI [0:ROM_DEPTH-1] = '{
    7'h00, 7'h1B, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E, 7'h26, 7'h2A,
    7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09, 7'h51, 7'h57, 7'h45, 7'h52,
    7'h54, 7'h59, 7'h55, 7'h49, 7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0D, 7'h00,
    7'h41, 7'h53, 7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
    7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56, 7'h42, 7'h4E,
    7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h2A, 7'h00, 7'h20, 7'h00
  };

  // digit and symbol keys ignore caps lock
  function automatic logic shift_only_key(input logic [7:0] c);
    return (c < DIGIT_LIMIT) || (c == KEY_BACKTICK) ||
           (c == 8'h1A) || (c == 8'h1B) || (c == 8'h2B) || (c == 8'h27) ||
           (c == 8'h28) || (c == 8'h33) || (c == 8'h34) || (c == 8'h35);
  endfunction

endpackage

### rtl/keyboard_scancode_to_ascii.sv
// top level of the set-1 scan code to ascii decoder
// depends on kbd_pkg, kbd_ram, kbd_decode and assert_macros.svh
//
//   channel | ports                                       | direction
//   in      | in_valid, in_stall, in_scan_byte            | byte from keyboard
//   out     | out_valid, out_stall, out_ascii_char,       | decoded character
//           | out_ctrl_held, out_alt_held                 |
//
// one item per cycle unless the output stalls: an item is decoded in the cycle
// after it is taken; its character is registered as the decode stage advances.
// the one-entry state memory is read every cycle; its registered read lags a
// write-back, so the last write-back is forwarded. it has no reset: a flag
// cleared by reset makes it read as zero until the first write. a stalled full
// output holds a decode item with a character, which then stalls the input.
`include "assert_macros.svh"
module keyboard_scancode_to_ascii (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_scan_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [6:0] out_ascii_char,
  output logic       out_ctrl_held,
  output logic       out_alt_held
);
  localparam int SAW = (kbd_pkg::STATE_DEPTH > 1) ? $clog2(kbd_pkg::STATE_DEPTH) : 1;
  localparam logic [SAW-1:0] STATE_ADDR = '0;

  logic                 s1_v_r, s1_v_nxt;
  logic [7:0]           s1_byte_r;
  logic                 st_valid_r;
  logic                 wr_fire_r;
  kbd_pkg::kbd_state_t  wr_data_r;
  logic [kbd_pkg::STATE_W-1:0] ram_q;
  kbd_pkg::kbd_state_t  st_cur, st_nxt;
  kbd_pkg::kbd_result_t res;
  logic                 out_free;
  logic                 s1_adv;
  logic                 in_acc;
  logic                 out_v_r, out_v_nxt;
  logic [6:0]           out_char_r;
  logic                 out_ctrl_r, out_alt_r;

  // state memory
  kbd_ram #(
    .WIDTH (kbd_pkg::STATE_W),
    .DEPTH (kbd_pkg::STATE_DEPTH)
  ) u_state_ram (
    .clk     (clk),
    .wr_en   (s1_adv),
    .wr_addr (STATE_ADDR),
    .wr_data (st_nxt),
    .rd_addr (STATE_ADDR),
    .rd_data (ram_q)
  );

  // current state: forward last write, zero before first write
  always_comb begin
    if (wr_fire_r) begin
      st_cur = wr_data_r;
    end else if (st_valid_r) begin
      st_cur = kbd_pkg::kbd_state_t'(ram_q);
    end else begin
      st_cur = '0;
    end
  end

  kbd_decode u_decode (
    .scan_byte (s1_byte_r),
    .st_cur    (st_cur),
    .st_nxt    (st_nxt),
    .res       (res)
  );

  // stage control
  assign out_free  = !out_v_r || !out_stall;
  assign s1_adv    = s1_v_r && (out_free || !res.emit);
  assign in_stall  = s1_v_r && !s1_adv;
  assign in_acc    = in_valid && !in_stall;
  assign s1_v_nxt  = in_acc || (s1_v_r && !s1_adv);
  assign out_v_nxt = (s1_adv && res.emit) || (out_v_r && out_stall);

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r     <= 1'b0;
      out_v_r    <= 1'b0;
      st_valid_r <= 1'b0;
      wr_fire_r  <= 1'b0;
    end else begin
      s1_v_r    <= s1_v_nxt;
      out_v_r   <= out_v_nxt;
      wr_fire_r <= s1_adv;
      if (s1_adv) begin
        st_valid_r <= 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_byte_r <= in_scan_byte;
    end
    if (s1_adv) begin
      wr_data_r <= st_nxt;
    end
    if (s1_adv && res.emit) begin
      out_char_r <= res.ascii_char;
      out_ctrl_r <= res.ctrl_held;
      out_alt_r  <= res.alt_held;
    end
  end

  assign out_valid      = out_v_r;
  assign out_ascii_char = out_char_r;
  assign out_ctrl_held  = out_ctrl_r;
  assign out_alt_held   = out_alt_r;

  // checks
  `ASSERT_CLK_RST(a_emit_nonzero, clk, rst_n, out_valid |-> (out_ascii_char != 7'h00), "zero character emitted")
  `ASSERT_CLK(a_stall_needs_item, clk, in_stall |-> s1_v_r, "input stalled with empty decode stage")
  `ASSERT_CLK_RST(a_fwd_after_valid, clk, rst_n, wr_fire_r |-> st_valid_r, "forward without state write")
  `ASSERT_CLK_RST(a_s1_hold, clk, rst_n, (s1_v_r && !s1_adv) |=> (s1_v_r && $stable(s1_byte_r)), "held item lost")
endmodule

### rtl/kbd_ram.sv
// generic single-port-write ram with registered read
// no dependencies
module kbd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);
  logic [WIDTH-1:0] mem [0:DEPTH-1];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read, old data on a same-cycle write
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end
endmodule

### rtl/kbd_decode.sv
// combinational decode of one scan byte against the current state
// depends on kbd_pkg
module kbd_decode (
  input  logic [7:0]          scan_byte,
  input  kbd_pkg::kbd_state_t st_cur,
  output kbd_pkg::kbd_state_t st_nxt,
  output kbd_pkg::kbd_result_t res
);
  logic                      brk;
  logic [6:0]                key;
  logic                      col;
  logic [kbd_pkg::ROM_AW-1:0] idx;
  logic [6:0]                ch;
  logic                      in_rom;

  assign brk    = scan_byte[7];
  assign key    = scan_byte[6:0];
  assign in_rom = (scan_byte != 8'h00) && (scan_byte < kbd_pkg::ROM_LIMIT);
  assign idx    = scan_byte[kbd_pkg::ROM_AW-1:0];

  // column choice: digits and symbols on shift alone
  assign col = kbd_pkg::shift_only_key(scan_byte) ? st_cur.shift
                                                  : (st_cur.shift ^ st_cur.caps);

  // rom lookup, only meaningful when in range
  assign ch = in_rom ? (col ? kbd_pkg::ROM_HI[idx] : kbd_pkg::ROM_LO[idx]) : 7'h00;

  // state update and result
  always_comb begin
    st_nxt         = st_cur;
    st_nxt.extend  = 1'b0;
    res.emit       = 1'b0;
    res.ascii_char = ch;
    res.ctrl_held  = st_cur.ctrl;
    res.alt_held   = st_cur.alt;
    priority if (scan_byte == kbd_pkg::PREFIX_BYTE) begin
      st_nxt.extend = 1'b1;
    end else if (brk) begin
      // release: shift only without prefix
      if (key == kbd_pkg::KEY_CTRL) begin
        st_nxt.ctrl = 1'b0;
      end else if (!st_cur.extend &&
                   (key == kbd_pkg::KEY_SHIFT_L || key == kbd_pkg::KEY_SHIFT_R)) begin
        st_nxt.shift = 1'b0;
      end else if (key == kbd_pkg::KEY_ALT) begin
        st_nxt.alt = 1'b0;
      end
    end else if (st_cur.extend) begin
      // extended make: right ctrl and alt
      if (key == kbd_pkg::KEY_CTRL) begin
        st_nxt.ctrl = 1'b1;
      end else if (key == kbd_pkg::KEY_ALT) begin
        st_nxt.alt = 1'b1;
      end
    end else if (in_rom) begin
      if (ch != 7'h00) begin
        res.emit = 1'b1;
      end else if (key == kbd_pkg::KEY_CTRL) begin
        st_nxt.ctrl = 1'b1;
      end else if (key == kbd_pkg::KEY_SHIFT_L || key == kbd_pkg::KEY_SHIFT_R) begin
        st_nxt.shift = 1'b1;
      end else if (key == kbd_pkg::KEY_ALT) begin
        st_nxt.alt = 1'b1;
      end else if (key == kbd_pkg::KEY_CAPS) begin
        st_nxt.caps = ~st_cur.caps;
      end
    end
  end
endmodule
